// File: rtl/jsu_pkg.sv
// Shared types, constants and helper functions of the JSON string unescape block.
package jsu_pkg;

  // Depth of the queue between the decoder and the byte emitter.
  localparam int unsigned QueueDepth = 4;

  // Byte values that the decoder reacts to.
  localparam logic [7:0] CharQuote  = 8'h22;
  localparam logic [7:0] CharBslash = 8'h5C;
  localparam logic [7:0] CharSlash  = 8'h2F;
  localparam logic [7:0] CharNul    = 8'h00;
  localparam logic [7:0] CharSpace  = 8'h20;
  localparam logic [7:0] CharLowB   = 8'h62;
  localparam logic [7:0] CharLowF   = 8'h66;
  localparam logic [7:0] CharLowN   = 8'h6E;
  localparam logic [7:0] CharLowR   = 8'h72;
  localparam logic [7:0] CharLowT   = 8'h74;
  localparam logic [7:0] CharLowU   = 8'h75;

  // Control codes produced by the short escapes.
  localparam logic [7:0] CodeBs = 8'h08;
  localparam logic [7:0] CodeFf = 8'h0C;
  localparam logic [7:0] CodeLf = 8'h0A;
  localparam logic [7:0] CodeCr = 8'h0D;
  localparam logic [7:0] CodeHt = 8'h09;

  // Surrogate ranges, identified by the top six bits of a 16-bit group.
  localparam logic [5:0] SurrHighTag = 6'b110110;
  localparam logic [5:0] SurrLowTag  = 6'b110111;
  localparam logic [20:0] SuppBase   = 21'h10000;

  // UTF-8 length limits.
  localparam logic [20:0] Utf8Max1 = 21'h7F;
  localparam logic [20:0] Utf8Max2 = 21'h7FF;
  localparam logic [20:0] Utf8Max3 = 21'hFFFF;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_DATA    = 3'd0,
    ST_END     = 3'd1,
    ST_NOQUOTE = 3'd2,
    ST_CTRL    = 3'd3,
    ST_ESCAPE  = 3'd4,
    ST_HEX     = 3'd5,
    ST_SURR    = 3'd6
  } status_e;

  // Decoder modes, one-hot.
  typedef enum logic [5:0] {
    MODE_NORMAL  = 6'b000001,
    MODE_ESC     = 6'b000010,
    MODE_HEX1    = 6'b000100,
    MODE_WANT_BS = 6'b001000,
    MODE_WANT_U  = 6'b010000,
    MODE_HEX2    = 6'b100000
  } mode_e;

  // One decoded job: up to four result bytes, index of the final one, status.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
    status_e         status;
  } jsu_job_t;

  // Hex digit decode: bit 4 is set for a valid digit, bits 3:0 hold its value.
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    r = '0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end
    return r;
  endfunction

  // A single result with the given status and byte.
  function automatic jsu_job_t single_job(input status_e st, input logic [7:0] b);
    jsu_job_t j;
    j          = '0;
    j.status   = st;
    j.bytes[0] = b;
    return j;
  endfunction

  // UTF-8 encoding of one code point into a data job.
  function automatic jsu_job_t encode_job(input logic [20:0] cp);
    jsu_job_t j;
    j        = '0;
    j.status = ST_DATA;
    if (cp <= Utf8Max1) begin
      j.bytes[0] = cp[7:0];
      j.last_idx = 2'd0;
    end else if (cp <= Utf8Max2) begin
      j.bytes[0] = {3'b110, cp[10:6]};
      j.bytes[1] = {2'b10, cp[5:0]};
      j.last_idx = 2'd1;
    end else if (cp <= Utf8Max3) begin
      j.bytes[0] = {4'b1110, cp[15:12]};
      j.bytes[1] = {2'b10, cp[11:6]};
      j.bytes[2] = {2'b10, cp[5:0]};
      j.last_idx = 2'd2;
    end else begin
      j.bytes[0] = {5'b11110, cp[20:18]};
      j.bytes[1] = {2'b10, cp[17:12]};
      j.bytes[2] = {2'b10, cp[11:6]};
      j.bytes[3] = {2'b10, cp[5:0]};
      j.last_idx = 2'd3;
    end
    return j;
  endfunction

endpackage

// File: rtl/jsu_front.sv
// Front end: accepts string bytes, runs the escape decoder and forms result jobs.
module jsu_front
  import jsu_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic     start_req_i,
  input  logic     full_i,
  output logic     push_o,
  output jsu_job_t job_o
);

  mode_e       mode_q, mode_d, mode_eff;
  logic [15:0] hex_q, hex_d, hex_eff, hex_new;
  logic [9:0]  high_q, high_d, high_eff;
  logic [1:0]  cnt_q, cnt_d, cnt_eff;
  logic        halted_q, halted_d, halted_eff;
  logic        accept;
  logic [4:0]  digit;
  logic [20:0] pair_cp;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;

  // A start request clears the decoder before the byte is decoded.
  always_comb begin
    if (start_req_i) begin
      mode_eff   = MODE_NORMAL;
      hex_eff    = '0;
      high_eff   = '0;
      cnt_eff    = '0;
      halted_eff = 1'b0;
    end else begin
      mode_eff   = mode_q;
      hex_eff    = hex_q;
      high_eff   = high_q;
      cnt_eff    = cnt_q;
      halted_eff = halted_q;
    end
  end

  assign digit   = hex_digit(in_byte_i);
  assign hex_new = {hex_eff[11:0], digit[3:0]};
  assign pair_cp = {1'b0, high_eff, hex_new[9:0]} + SuppBase;

  // Decoder step for one accepted item.
  always_comb begin
    mode_d   = mode_q;
    hex_d    = hex_q;
    high_d   = high_q;
    cnt_d    = cnt_q;
    halted_d = halted_q;
    push_o   = 1'b0;
    job_o    = '0;
    if (accept) begin
      mode_d   = mode_eff;
      hex_d    = hex_eff;
      high_d   = high_eff;
      cnt_d    = cnt_eff;
      halted_d = halted_eff;
      if (!halted_eff) begin
        unique case (mode_eff)
          MODE_NORMAL: begin
            priority if (in_byte_i == CharQuote) begin
              push_o   = 1'b1;
              job_o    = single_job(ST_END, 8'h00);
              halted_d = 1'b1;
            end else if (in_byte_i == CharNul) begin
              push_o   = 1'b1;
              job_o    = single_job(ST_NOQUOTE, 8'h00);
              halted_d = 1'b1;
            end else if (in_byte_i == CharBslash) begin
              mode_d = MODE_ESC;
            end else if (in_byte_i < CharSpace) begin
              push_o   = 1'b1;
              job_o    = single_job(ST_CTRL, 8'h00);
              halted_d = 1'b1;
            end else begin
              push_o = 1'b1;
              job_o  = single_job(ST_DATA, in_byte_i);
            end
          end
          MODE_ESC: begin
            mode_d = MODE_NORMAL;
            push_o = 1'b1;
            unique case (in_byte_i)
              CharQuote, CharBslash, CharSlash: job_o = single_job(ST_DATA, in_byte_i);
              CharLowB: job_o = single_job(ST_DATA, CodeBs);
              CharLowF: job_o = single_job(ST_DATA, CodeFf);
              CharLowN: job_o = single_job(ST_DATA, CodeLf);
              CharLowR: job_o = single_job(ST_DATA, CodeCr);
              CharLowT: job_o = single_job(ST_DATA, CodeHt);
              CharLowU: begin
                push_o = 1'b0;
                mode_d = MODE_HEX1;
                hex_d  = '0;
                cnt_d  = '0;
              end
              default: begin
                job_o    = single_job(ST_ESCAPE, 8'h00);
                halted_d = 1'b1;
              end
            endcase
          end
          MODE_HEX1, MODE_HEX2: begin
            if (!digit[4]) begin
              push_o   = 1'b1;
              job_o    = single_job(ST_HEX, 8'h00);
              halted_d = 1'b1;
              mode_d   = MODE_NORMAL;
            end else begin
              hex_d = hex_new;
              if (cnt_eff != 2'd3) begin
                cnt_d = cnt_eff + 2'd1;
              end else begin
                cnt_d = '0;
                if (mode_eff == MODE_HEX1) begin
                  if (hex_new[15:10] == SurrHighTag) begin
                    high_d = hex_new[9:0];
                    mode_d = MODE_WANT_BS;
                  end else begin
                    mode_d = MODE_NORMAL;
                    push_o = 1'b1;
                    job_o  = encode_job({5'b0, hex_new});
                  end
                end else if (hex_new[15:10] != SurrLowTag) begin
                  push_o   = 1'b1;
                  job_o    = single_job(ST_SURR, 8'h00);
                  halted_d = 1'b1;
                  mode_d   = MODE_NORMAL;
                end else begin
                  mode_d = MODE_NORMAL;
                  push_o = 1'b1;
                  job_o  = encode_job(pair_cp);
                end
              end
            end
          end
          MODE_WANT_BS: begin
            if (in_byte_i == CharBslash) begin
              mode_d = MODE_WANT_U;
            end else begin
              push_o   = 1'b1;
              job_o    = single_job(ST_SURR, 8'h00);
              halted_d = 1'b1;
              mode_d   = MODE_NORMAL;
            end
          end
          MODE_WANT_U: begin
            if (in_byte_i == CharLowU) begin
              mode_d = MODE_HEX2;
              hex_d  = '0;
              cnt_d  = '0;
            end else begin
              push_o   = 1'b1;
              job_o    = single_job(ST_SURR, 8'h00);
              halted_d = 1'b1;
              mode_d   = MODE_NORMAL;
            end
          end
          default: begin
            mode_d = MODE_NORMAL;
          end
        endcase
      end
    end
  end

  // Decoder state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_NORMAL;
      hex_q    <= '0;
      high_q   <= '0;
      cnt_q    <= '0;
      halted_q <= 1'b1;
    end else begin
      mode_q   <= mode_d;
      hex_q    <= hex_d;
      high_q   <= high_d;
      cnt_q    <= cnt_d;
      halted_q <= halted_d;
    end
  end

endmodule

// File: rtl/jsu_queue.sv
// Small register queue of decoded jobs between the front and back ends.
module jsu_queue
  import jsu_pkg::*;
#(
  parameter int unsigned DEPTH = QueueDepth
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  jsu_job_t job_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     valid_o,
  output jsu_job_t head_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  jsu_job_t           store_q [DEPTH];
  logic [PtrW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign valid_o = (cnt_q != '0);
  assign head_o  = store_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointer and fill count update.
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == LastPtr) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == LastPtr) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_q] <= job_i;
    end
  end

endmodule

// File: rtl/jsu_back.sv
// Back end: walks each queued job and emits its bytes through an output register.
module jsu_back
  import jsu_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       head_valid_i,
  input  jsu_job_t   head_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic [2:0] status_o,
  output logic       last_o
);

  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q, out_byte_d;
  status_e    status_q, status_d;
  logic       last_q, last_d;
  logic [1:0] idx_q, idx_d;
  logic       load, at_last;

  assign load    = head_valid_i && (!out_valid_q || out_ready_i);
  assign at_last = (idx_q == head_i.last_idx);
  assign pop_o   = load && at_last;

  // Next output item and byte index.
  always_comb begin
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    status_d    = status_q;
    last_d      = last_q;
    idx_d       = idx_q;
    if (load) begin
      out_valid_d = 1'b1;
      out_byte_d  = head_i.bytes[idx_q];
      status_d    = head_i.status;
      last_d      = at_last;
      idx_d       = at_last ? 2'd0 : idx_q + 2'd1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
    end
  end

  // Output payload.
  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    status_q   <= status_d;
    last_q     <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign status_o    = status_q;
  assign last_o      = last_q;

endmodule

// File: rtl/json_string_unescape_utf8.sv
// Top level of the JSON string unescape to UTF-8 decoder.
//
// The block takes one string body byte per cycle while its queue is not full
// and decodes it in the same cycle in the front end, which turns every byte
// that completes something into a job of one to four result items (UTF-8
// bytes, an end marker or an error code). Jobs wait in a QUEUE_DEPTH-entry
// queue; the back end sends one result item per cycle while out_ready_i is
// high, through an output register, with last set on the final item of each
// input byte. Plain text and short escapes thus run at one byte per cycle in
// and out when nothing stalls; a \u code point gives one result item per
// UTF-8 byte, sent while the front end keeps taking bytes until the queue is
// full. Jobs are registered in the queue, their items in the output register.
module json_string_unescape_utf8
  import jsu_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       start_req_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic [2:0] status_o,
  output logic       last_o
);

  logic     push, full, pop, head_valid;
  jsu_job_t job, head;

  jsu_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_byte_i   (in_byte_i),
    .start_req_i (start_req_i),
    .full_i      (full),
    .push_o      (push),
    .job_o       (job)
  );

  jsu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .head_o  (head)
  );

  jsu_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .status_o     (status_o),
    .last_o       (last_o)
  );

endmodule

// File: tb/unescape_check_pkg.sv
// Scoreboard class for the JSON string unescape testbench: decoder model and result check.
package unescape_check_pkg;
  import jsu_pkg::*;

  // One result item as the block should send it.
  typedef struct {
    logic [7:0] data;
    status_e    st;
    logic       fin;
  } utf8_item_t;

  class unescape_scoreboard;
    // Decoder state, kept in step with the block.
    mode_e       mode;
    logic [15:0] group;
    logic [9:0]  high_half;
    logic [1:0]  digits;
    bit          halted;

    // Result items still owed by the block, oldest first.
    utf8_item_t  text_q[$];
    // Result items of the byte being decoded.
    utf8_item_t  step_q[$];

    int unsigned n_bytes;
    int unsigned n_results;
    int unsigned n_errors;
    int unsigned n_fail;

    function new();
      mode      = MODE_NORMAL;
      group     = '0;
      high_half = '0;
      digits    = '0;
      halted    = 1'b1;
      n_bytes   = 0;
      n_results = 0;
      n_errors  = 0;
      n_fail    = 0;
    endfunction

    function void emit(logic [7:0] b, status_e st);
      utf8_item_t r;
      r.data = b;
      r.st   = st;
      r.fin  = 1'b0;
      step_q = {step_q, r};
    endfunction

    // Any error reports its code once and stops decoding until the next start.
    function void stop_on(status_e st);
      halted = 1'b1;
      mode   = MODE_NORMAL;
      emit(8'h00, st);
    endfunction

    // UTF-8 byte sequence of one code point.
    function void encode_cp(logic [20:0] cp);
      if (cp <= 21'h7F) begin
        emit(cp[7:0], ST_DATA);
      end else if (cp <= 21'h7FF) begin
        emit(8'hC0 | 8'(cp >> 6), ST_DATA);
        emit(8'h80 | 8'(cp & 21'h3F), ST_DATA);
      end else if (cp <= 21'hFFFF) begin
        emit(8'hE0 | 8'(cp >> 12), ST_DATA);
        emit(8'h80 | 8'((cp >> 6) & 21'h3F), ST_DATA);
        emit(8'h80 | 8'(cp & 21'h3F), ST_DATA);
      end else begin
        emit(8'hF0 | 8'(cp >> 18), ST_DATA);
        emit(8'h80 | 8'((cp >> 12) & 21'h3F), ST_DATA);
        emit(8'h80 | 8'((cp >> 6) & 21'h3F), ST_DATA);
        emit(8'h80 | 8'(cp & 21'h3F), ST_DATA);
      end
    endfunction

    // Value of an ASCII hex digit, or -1 for any other byte.
    function int digit_of(logic [7:0] b);
      if (b >= 8'h30 && b <= 8'h39) return int'(b) - 'h30;
      if (b >= 8'h41 && b <= 8'h46) return int'(b) - 'h41 + 10;
      if (b >= 8'h61 && b <= 8'h66) return int'(b) - 'h61 + 10;
      return -1;
    endfunction

    // Decode one byte of an active string into step_q.
    function void decode(logic [7:0] b);
      int          d;
      logic [20:0] cp;
      case (mode)
        MODE_NORMAL: begin
          if (b == CharQuote) begin
            halted = 1'b1;
            emit(8'h00, ST_END);
          end else if (b == CharNul) begin
            stop_on(ST_NOQUOTE);
          end else if (b == CharBslash) begin
            mode = MODE_ESC;
          end else if (b < CharSpace) begin
            stop_on(ST_CTRL);
          end else begin
            emit(b, ST_DATA);
          end
        end
        MODE_ESC: begin
          mode = MODE_NORMAL;
          case (b)
            CharQuote, CharBslash, CharSlash: emit(b, ST_DATA);
            CharLowB: emit(CodeBs, ST_DATA);
            CharLowF: emit(CodeFf, ST_DATA);
            CharLowN: emit(CodeLf, ST_DATA);
            CharLowR: emit(CodeCr, ST_DATA);
            CharLowT: emit(CodeHt, ST_DATA);
            CharLowU: begin
              mode   = MODE_HEX1;
              group  = '0;
              digits = '0;
            end
            default: stop_on(ST_ESCAPE);
          endcase
        end
        MODE_HEX1, MODE_HEX2: begin
          d = digit_of(b);
          if (d < 0) begin
            stop_on(ST_HEX);
            return;
          end
          group = {group[11:0], 4'(d)};
          if (digits != 2'd3) begin
            digits++;
            return;
          end
          digits = '0;
          if (mode == MODE_HEX1) begin
            // A high surrogate waits for its low half.
            if (group >= 16'hD800 && group <= 16'hDBFF) begin
              high_half = 10'(group - 16'hD800);
              mode      = MODE_WANT_BS;
            end else begin
              mode = MODE_NORMAL;
              encode_cp(21'(group));
            end
          end else if (group < 16'hDC00 || group > 16'hDFFF) begin
            stop_on(ST_SURR);
          end else begin
            mode = MODE_NORMAL;
            cp   = (21'(high_half) << 10) | 21'(group - 16'hDC00);
            encode_cp(cp + SuppBase);
          end
        end
        MODE_WANT_BS: begin
          if (b != CharBslash) stop_on(ST_SURR);
          else mode = MODE_WANT_U;
        end
        MODE_WANT_U: begin
          if (b != CharLowU) begin
            stop_on(ST_SURR);
          end else begin
            mode   = MODE_HEX2;
            group  = '0;
            digits = '0;
          end
        end
        default: mode = MODE_NORMAL;
      endcase
    endfunction

    // An item was accepted: queue the results it should cause.
    function void note_input(logic [7:0] b, logic start);
      n_bytes++;
      step_q.delete();
      if (start) begin
        mode      = MODE_NORMAL;
        group     = '0;
        high_half = '0;
        digits    = '0;
        halted    = 1'b0;
      end
      if (halted) return;
      decode(b);
      if (step_q.size() > 0) step_q[step_q.size() - 1].fin = 1'b1;
      foreach (step_q[i]) text_q = {text_q, step_q[i]};
    endfunction

    // A result item was accepted: compare it with the oldest one owed.
    function void check_result(logic [7:0] b, logic [2:0] st, logic fin);
      utf8_item_t e;
      n_results++;
      if (st >= ST_NOQUOTE) n_errors++;
      if (text_q.size() == 0) begin
        $error("result item with nothing owed: out_byte %h status %0d last %0b", b, st, fin);
        n_fail++;
        return;
      end
      e = text_q.pop_front();
      if (b !== e.data) begin
        $error("out_byte: expected %h, got %h", e.data, b);
        n_fail++;
      end
      if (st !== e.st) begin
        $error("status: expected %0d, got %0d", e.st, st);
        n_fail++;
      end
      if (fin !== e.fin) begin
        $error("last: expected %0b, got %0b", e.fin, fin);
        n_fail++;
      end
    endfunction
  endclass

endpackage

// File: tb/json_string_unescape_utf8_test.sv
// Top of the JSON string unescape testbench: stimulus, handshakes and end of run.
module json_string_unescape_utf8_test;
  timeunit 1ns;
  timeprecision 1ps;

  import jsu_pkg::*;
  import unescape_check_pkg::*;

  localparam int unsigned NumItems    = 460;
  localparam int unsigned HoldCycles  = 120;
  localparam int unsigned DrainCycles = 20;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  logic [7:0] in_byte_i   = 8'h00;
  logic       start_req_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [7:0] out_byte_o;
  logic [2:0] status_o;
  logic       last_o;

  unescape_scoreboard sb = new();

  // Byte stream to send, with the start flag of each item.
  logic [7:0] stim_byte_q[$];
  bit         stim_start_q[$];
  bit         opening;
  int unsigned n_strings;

  // Shared between sender and receiver.
  bit calm;
  bit hold_req;
  bit hold_done;

  json_string_unescape_utf8 i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_byte_i  (in_byte_i),
    .start_req_i(start_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_byte_o (out_byte_o),
    .status_o   (status_o),
    .last_o     (last_o)
  );

  // Clock, 8 ns period.
  always begin
    #4ns clk_i = 1'b1;
    #4ns clk_i = 1'b0;
  end

  // Append one byte; the first byte of a string carries the start flag.
  task automatic put_byte(logic [7:0] b);
    stim_byte_q  = {stim_byte_q, b};
    stim_start_q = {stim_start_q, opening};
    opening = 1'b0;
  endtask

  function automatic logic [7:0] hex_char(logic [3:0] v);
    if (v < 4'd10) return 8'h30 + 8'(v);
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
  endfunction

  function automatic bit is_hex_char(logic [7:0] b);
    return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46) ||
           (b >= 8'h61 && b <= 8'h66);
  endfunction

  function automatic bit is_escape_char(logic [7:0] b);
    return b == CharQuote || b == CharBslash || b == CharSlash || b == CharLowB ||
           b == CharLowF || b == CharLowN || b == CharLowR || b == CharLowT ||
           b == CharLowU;
  endfunction

  // A \u escape with four hex digits of mixed case.
  task automatic put_group(logic [15:0] v);
    put_byte(CharBslash);
    put_byte(CharLowU);
    for (int i = 3; i >= 0; i--) put_byte(hex_char(v[4*i +: 4]));
  endtask

  function automatic logic [15:0] high_surr();
    return 16'hD800 + 16'($urandom_range(0, 'h3FF));
  endfunction

  // A \u value from the basic plane, spread over the one-, two- and three-byte UTF-8 lengths.
  function automatic logic [15:0] bmp_value();
    logic [15:0] edges[6] = '{16'h0000, 16'h007F, 16'h0080, 16'h07FF, 16'h0800, 16'hFFFF};
    case ($urandom_range(0, 5))
      0: return 16'($urandom_range(0, 'h7F));
      1: return 16'($urandom_range('h80, 'h7FF));
      2: return 16'($urandom_range('h800, 'hD7FF));
      3: return 16'($urandom_range('hE000, 'hFFFF));
      4: return 16'($urandom_range('hDC00, 'hDFFF));
      default: return edges[$urandom_range(0, 5)];
    endcase
  endfunction

  // One piece of well-formed string content.
  task automatic add_token();
    logic [7:0] esc[8] = '{CharQuote, CharBslash, CharSlash, CharLowB,
                           CharLowF, CharLowN, CharLowR, CharLowT};
    logic [7:0] b;
    case ($urandom_range(0, 9))
      4, 5: begin
        put_byte(CharBslash);
        put_byte(esc[$urandom_range(0, 7)]);
      end
      6: put_group(bmp_value());
      7: begin
        put_group(high_surr());
        put_group(16'hDC00 + 16'($urandom_range(0, 'h3FF)));
      end
      default: begin
        do b = 8'($urandom_range('h20, 'hFF));
        while (b == CharQuote || b == CharBslash);
        put_byte(b);
      end
    endcase
  endtask

  // A broken piece of content, then a few bytes that the block must ignore.
  task automatic add_fault();
    logic [7:0]  b;
    logic [15:0] v;
    case ($urandom_range(0, 7))
      0: put_byte(CharNul);
      1: put_byte(8'($urandom_range(1, 'h1F)));
      2: begin
        put_byte(CharBslash);
        do b = 8'($urandom_range(0, 255));
        while (is_escape_char(b));
        put_byte(b);
      end
      3: begin
        put_byte(CharBslash);
        put_byte(CharLowU);
        repeat ($urandom_range(0, 3)) put_byte(hex_char(4'($urandom_range(0, 15))));
        do b = 8'($urandom_range(0, 255));
        while (is_hex_char(b));
        put_byte(b);
      end
      4: begin
        put_group(high_surr());
        do b = 8'($urandom_range(0, 255));
        while (b == CharBslash);
        put_byte(b);
      end
      5: begin
        put_group(high_surr());
        put_byte(CharBslash);
        do b = 8'($urandom_range(0, 255));
        while (b == CharLowU);
        put_byte(b);
      end
      6: begin
        put_group(high_surr());
        do v = 16'($urandom_range(0, 'hFFFF));
        while (v >= 16'hDC00 && v <= 16'hDFFF);
        put_group(v);
      end
      default: begin
        // NUL byte inside an escape, a hex group or a surrogate pair.
        case ($urandom_range(0, 3))
          0: put_byte(CharBslash);
          1: begin
            put_byte(CharBslash);
            put_byte(CharLowU);
            repeat ($urandom_range(0, 3)) put_byte(hex_char(4'($urandom_range(0, 15))));
          end
          2: put_group(high_surr());
          default: begin
            put_group(high_surr());
            put_byte(CharBslash);
          end
        endcase
        put_byte(CharNul);
      end
    endcase
    repeat ($urandom_range(0, 3)) put_byte(8'($urandom_range(0, 255)));
  endtask

  // A random string body; about one in five is broken, one in ten of the rest lacks the quote.
  task automatic add_string();
    int unsigned n_tok;
    int unsigned bad_at;
    n_strings++;
    opening = 1'b1;
    n_tok   = $urandom_range(1, 8);
    bad_at  = ($urandom_range(0, 99) < 20) ? $urandom_range(0, n_tok - 1) : n_tok;
    for (int i = 0; i < n_tok; i++) begin
      if (i == bad_at) begin
        add_fault();
        return;
      end
      add_token();
    end
    if ($urandom_range(0, 9) != 0) put_byte(CharQuote);
  endtask

  // Short directed strings: halted input, a 4-byte code point and each error kind.
  task automatic add_directed();
    opening = 1'b0;
    put_byte(8'h78);
    opening = 1'b1;
    put_group(16'hD83D);
    put_group(16'hDE00);
    put_byte(CharQuote);
    opening = 1'b1;
    put_byte(CharNul);
    opening = 1'b1;
    put_byte(8'h1F);
    opening = 1'b1;
    put_byte(CharBslash);
    put_byte(8'h71);
    opening = 1'b1;
    put_byte(CharBslash);
    put_byte(CharLowU);
    put_byte(8'h30);
    put_byte(8'h67);
    opening = 1'b1;
    put_group(16'hD800);
    put_byte(8'h78);
    n_strings += 6;
  endtask

  // Offer one item and hold it until the block takes it.
  task automatic send_byte(logic [7:0] b, bit start);
    bit hit;
    while (!calm && $urandom_range(0, 99) < 30) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    in_byte_i   <= b;
    start_req_i <= start;
    do begin
      @(negedge clk_i);
      hit = in_ready_o;
      @(posedge clk_i);
    end while (!hit);
    sb.note_input(b, start);
  endtask

  // Receiver: random stalls, one long hold-off, and a calm stretch.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_done = 1'b1;
      end
      out_ready_i <= calm || ($urandom_range(0, 99) >= 30);
    end
  end

  // Result monitor: sample before the edge, check at the edge.
  initial begin
    logic [7:0] b;
    logic [2:0] st;
    logic       fin;
    forever begin
      @(negedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        b   = out_byte_o;
        st  = status_o;
        fin = last_o;
        @(posedge clk_i);
        sb.check_result(b, st, fin);
      end
    end
  end

  // Main sequence.
  initial begin
    int unsigned n_total;
    int unsigned fails;
    add_directed();
    n_total = NumItems;
    while (stim_byte_q.size() < n_total) add_string();

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_byte_q[i]) begin
      calm = (i >= 250 && i < 350);
      if (i == 120) hold_req = 1'b1;
      send_byte(stim_byte_q[i], stim_start_q[i]);
    end
    in_valid_i <= 1'b0;

    while (sb.text_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    fails = sb.n_fail + sb.text_q.size();
    $display("Sent %0d bytes in %0d string bodies and checked %0d result items.",
             sb.n_bytes, n_strings, sb.n_results);
    $display("%0d results carried an error code; output was held off %0d cycles once.",
             sb.n_errors, HoldCycles);
    if (fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// File: sim.f
rtl/jsu_pkg.sv
rtl/jsu_front.sv
rtl/jsu_queue.sv
rtl/jsu_back.sv
rtl/json_string_unescape_utf8.sv
tb/unescape_check_pkg.sv
tb/json_string_unescape_utf8_test.sv
